FILE: rtl/core/cbor_item_stream_parser_assert.svh
// ---------------------------------------------------------------------------
// CBOR item stream parser assertion macros
// Shared property forms for the checks at the end of the parser top level.
// ---------------------------------------------------------------------------
`ifndef CBOR_ITEM_STREAM_PARSER_ASSERT_SVH
`define CBOR_ITEM_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CBOR_ISP_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("cbor parser same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CBOR_ISP_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("cbor parser next-cycle check failed");

`endif

FILE: rtl/core/cbor_isp_pkg.sv
// ---------------------------------------------------------------------------
// CBOR item stream parser package
// Types, codes and constants shared by the parser modules.
// ---------------------------------------------------------------------------
package cbor_isp_pkg;

  // Parse phase, one-hot.
  typedef enum logic [3:0] {
    PH_HEAD = 4'b0001,
    PH_ARG  = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_DROP = 4'b1000
  } phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_HEAD    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Item types.
  localparam logic [3:0] TYPE_UINT    = 4'd0;
  localparam logic [3:0] TYPE_NINT    = 4'd1;
  localparam logic [3:0] TYPE_BYTES   = 4'd2;
  localparam logic [3:0] TYPE_TEXT    = 4'd3;
  localparam logic [3:0] TYPE_ARRAY   = 4'd4;
  localparam logic [3:0] TYPE_MAP     = 4'd5;
  localparam logic [3:0] TYPE_BOOL    = 4'd6;
  localparam logic [3:0] TYPE_NULL    = 4'd7;
  localparam logic [3:0] TYPE_FLOAT64 = 4'd8;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_RSVD_INFO  = 3'd1;
  localparam logic [2:0] ERR_TAG_SIMPLE = 3'd2;
  localparam logic [2:0] ERR_SHORT_HEAD = 3'd3;
  localparam logic [2:0] ERR_SHORT_STR  = 3'd4;

  // Head byte fields and special values.
  localparam logic [2:0] MAJOR_BYTES  = 3'd2;
  localparam logic [2:0] MAJOR_TEXT   = 3'd3;
  localparam logic [2:0] MAJOR_TAG    = 3'd6;
  localparam logic [2:0] MAJOR_SIMPLE = 3'd7;
  localparam logic [4:0] INFO_ARG1    = 5'd24;
  localparam logic [4:0] INFO_RSVD    = 5'd28;
  localparam logic [4:0] INFO_NULL    = 5'd22;
  localparam logic [4:0] INFO_FLOAT64 = 5'd27;
  localparam logic [7:0] BYTE_FALSE   = 8'hF4;
  localparam logic [7:0] BYTE_TRUE    = 8'hF5;
  localparam logic [7:0] BYTE_NULL    = 8'hF6;
  localparam logic [7:0] BYTE_FLOAT64 = 8'hFB;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  major;
    logic [4:0]  info;
    logic [3:0]  arg_left;
    logic [63:0] acc;
    logic [63:0] pay_left;
  } parse_state_t;

  // One result item plus its valid flag.
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [3:0]  item_type;
    logic [63:0] head_value;
    logic        wide_value;
    logic [7:0]  payload_byte;
    logic        string_end;
    logic [2:0]  error_code;
  } parse_result_t;

endpackage

FILE: rtl/core/cbor_item_stream_parser.sv
// ---------------------------------------------------------------------------
// CBOR item stream parser
// Decodes CBOR item heads and passes string payload bytes through.
// ---------------------------------------------------------------------------
// The parser takes one byte per clock unless in_stall is high and gives at
// most one result per byte. A byte is captured in an input register and
// decoded into the result register, from which the result is presented on
// the output; the sustained rate is one byte per cycle while the output does
// not stall, and the parse state (64-bit argument shift and payload
// count-down) is updated once for each byte.
// The input stalls only while the result register holds an unconsumed
// result that the output side is stalling. After an error, bytes are
// dropped up to and including the byte flagged as last.

module cbor_item_stream_parser
  import cbor_isp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [3:0]  out_item_type,
  output logic [63:0] out_head_value,
  output logic        out_wide_value,
  output logic [7:0]  out_payload_byte,
  output logic        out_string_end,
  output logic [2:0]  out_error_code
);

`include "cbor_item_stream_parser_assert.svh"

  logic          in_valid_r;
  logic [7:0]    in_byte_r;
  logic          in_last_r;
  parse_state_t  state_r;
  parse_state_t  state_nxt;
  parse_result_t res_nxt;
  parse_result_t out_r;
  logic          out_valid_r;
  logic          out_free;
  logic          proc;
  logic          out_is_err;
  logic          out_is_pay;
  logic          pay_is_str;

  // Handshake control.
  assign out_free = !out_valid_r || !out_stall;
  assign proc     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
      in_last_r <= in_is_last;
    end
  end

  // Byte decoder.
  cbor_isp_decode u_decode (
    .cur_state (state_r),
    .data_byte (in_byte_r),
    .data_last (in_last_r),
    .nxt_state (state_nxt),
    .result    (res_nxt)
  );

  // Parse state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_HEAD, major: '0, info: '0, arg_left: '0, acc: '0,
                   pay_left: '0};
    end else if (proc) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && res_nxt.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_nxt.valid) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_r.kind;
  assign out_item_type    = out_r.item_type;
  assign out_head_value   = out_r.head_value;
  assign out_wide_value   = out_r.wide_value;
  assign out_payload_byte = out_r.payload_byte;
  assign out_string_end   = out_r.string_end;
  assign out_error_code   = out_r.error_code;

  // Terms used by the checks below.
  assign out_is_err = out_valid_r && (out_r.kind == KIND_ERROR);
  assign out_is_pay = out_valid_r && (out_r.kind == KIND_PAYLOAD);
  assign pay_is_str = (out_r.item_type == TYPE_BYTES) || (out_r.item_type == TYPE_TEXT);

  // Checks on the parser's own logic.
  `CBOR_ISP_ASSERT_IMP(a_err_has_code, clk, rst_n, out_is_err, out_r.error_code != ERR_NONE)
  `CBOR_ISP_ASSERT_IMP(a_pay_is_string, clk, rst_n, out_is_pay, pay_is_str)
  `CBOR_ISP_ASSERT_IMP(a_arg_count_live, clk, rst_n, state_r.phase == PH_ARG, |state_r.arg_left)
  `CBOR_ISP_ASSERT_IMP(a_pay_count_live, clk, rst_n, state_r.phase == PH_PAY, |state_r.pay_left)
  `CBOR_ISP_ASSERT_NXT(a_last_to_head, clk, rst_n, proc && in_last_r, state_r.phase == PH_HEAD)

endmodule

FILE: rtl/core/cbor_isp_decode.sv
// ---------------------------------------------------------------------------
// CBOR item stream parser byte decoder
// Next-state and result logic for one input byte.
// ---------------------------------------------------------------------------
module cbor_isp_decode
  import cbor_isp_pkg::*;
(
  input  parse_state_t  cur_state,
  input  logic [7:0]    data_byte,
  input  logic          data_last,
  output parse_state_t  nxt_state,
  output parse_result_t result
);

  logic        fin;
  logic        simple_ok;
  logic [3:0]  fin_type;
  logic [63:0] fin_value;

  always_comb begin
    nxt_state = cur_state;
    result    = '0;
    fin       = 1'b0;
    fin_type  = TYPE_UINT;
    fin_value = '0;
    simple_ok = (data_byte == BYTE_FALSE) || (data_byte == BYTE_TRUE) ||
                (data_byte == BYTE_NULL)  || (data_byte == BYTE_FLOAT64);

    // Per-phase handling of the byte.
    unique case (cur_state.phase)
      PH_DROP: begin
        if (data_last) begin
          nxt_state.phase = PH_HEAD;
        end
      end
      PH_ARG: begin
        nxt_state.acc      = {cur_state.acc[55:0], data_byte};
        nxt_state.arg_left = cur_state.arg_left - 4'd1;
        if (nxt_state.arg_left == 4'd0) begin
          fin = 1'b1;
        end else if (data_last) begin
          nxt_state.phase   = PH_HEAD;
          result.valid      = 1'b1;
          result.kind       = KIND_ERROR;
          result.error_code = ERR_SHORT_HEAD;
        end
      end
      PH_PAY: begin
        if (cur_state.pay_left[63:1] == 63'd0) begin
          nxt_state.pay_left  = '0;
          nxt_state.phase     = PH_HEAD;
          result.valid        = 1'b1;
          result.kind         = KIND_PAYLOAD;
          result.item_type    = {1'b0, cur_state.major};
          result.payload_byte = data_byte;
          result.string_end   = 1'b1;
        end else if (data_last) begin
          nxt_state.phase   = PH_HEAD;
          result.valid      = 1'b1;
          result.kind       = KIND_ERROR;
          result.error_code = ERR_SHORT_STR;
        end else begin
          nxt_state.pay_left  = cur_state.pay_left - 64'd1;
          result.valid        = 1'b1;
          result.kind         = KIND_PAYLOAD;
          result.item_type    = {1'b0, cur_state.major};
          result.payload_byte = data_byte;
        end
      end
      PH_HEAD: begin
        nxt_state.major    = data_byte[7:5];
        nxt_state.info     = data_byte[4:0];
        nxt_state.acc      = '0;
        nxt_state.arg_left = 4'd0;
        if ((data_byte[7:5] == MAJOR_SIMPLE) && !simple_ok) begin
          nxt_state.phase   = data_last ? PH_HEAD : PH_DROP;
          result.valid      = 1'b1;
          result.kind       = KIND_ERROR;
          result.error_code = ERR_TAG_SIMPLE;
        end else if ((data_byte[7:5] != MAJOR_SIMPLE) &&
                     (data_byte[4:0] >= INFO_RSVD)) begin
          nxt_state.phase   = data_last ? PH_HEAD : PH_DROP;
          result.valid      = 1'b1;
          result.kind       = KIND_ERROR;
          result.error_code = ERR_RSVD_INFO;
        end else if (data_byte[7:5] == MAJOR_TAG) begin
          nxt_state.phase   = data_last ? PH_HEAD : PH_DROP;
          result.valid      = 1'b1;
          result.kind       = KIND_ERROR;
          result.error_code = ERR_TAG_SIMPLE;
        end else if (data_byte[4:0] < INFO_ARG1) begin
          nxt_state.acc = {59'd0, data_byte[4:0]};
          fin           = 1'b1;
        end else begin
          // Info 24 to 27 asks for 1, 2, 4 or 8 argument bytes.
          nxt_state.arg_left = 4'd1 << data_byte[1:0];
          if (data_last) begin
            nxt_state.phase   = PH_HEAD;
            result.valid      = 1'b1;
            result.kind       = KIND_ERROR;
            result.error_code = ERR_SHORT_HEAD;
          end else begin
            nxt_state.phase = PH_ARG;
          end
        end
      end
      default: begin
        nxt_state.phase = PH_HEAD;
      end
    endcase

    // A completed head is classified, then reported or opens a string.
    if (fin) begin
      if (nxt_state.major == MAJOR_SIMPLE) begin
        if (nxt_state.info == INFO_FLOAT64) begin
          fin_type  = TYPE_FLOAT64;
          fin_value = nxt_state.acc;
        end else if (nxt_state.info == INFO_NULL) begin
          fin_type  = TYPE_NULL;
          fin_value = '0;
        end else begin
          fin_type  = TYPE_BOOL;
          fin_value = {63'd0, nxt_state.info[0]};
        end
      end else begin
        fin_type  = {1'b0, nxt_state.major};
        fin_value = nxt_state.acc;
      end
      nxt_state.phase = PH_HEAD;
      if (((nxt_state.major == MAJOR_BYTES) || (nxt_state.major == MAJOR_TEXT)) &&
          (fin_value != 64'd0) && data_last) begin
        result.valid      = 1'b1;
        result.kind       = KIND_ERROR;
        result.error_code = ERR_SHORT_STR;
      end else begin
        if (((nxt_state.major == MAJOR_BYTES) || (nxt_state.major == MAJOR_TEXT)) &&
            (fin_value != 64'd0)) begin
          nxt_state.pay_left = fin_value;
          nxt_state.phase    = PH_PAY;
        end
        result.valid      = 1'b1;
        result.kind       = KIND_HEAD;
        result.item_type  = fin_type;
        result.head_value = fin_value;
        result.wide_value = |fin_value[63:32];
      end
    end
  end

endmodule

FILE: bench/tb_top.sv
// ---------------------------------------------------------------------------
// CBOR item stream parser testbench
// Feeds byte buffers through the parser with random gaps on the byte side
// and random stalls on the result side. Every transfer into the parser
// updates a software copy of the parse state. That copy predicts the head,
// payload or error result the byte causes. Each result transfer is compared
// field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;
  import cbor_isp_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int BYTE_TARGET  = 600;
  localparam int DRAIN_CYCLES = 8;

  // Opening buffers, each entry is {is_last, byte}.
  localparam int OPENING_LEN = 22;
  localparam logic [8:0] OPENING [OPENING_LEN] = '{
    9'h000, 9'h037,                 // uint 0, nint with largest direct info
    9'h019, 9'h012, 9'h034,         // uint with a two byte argument
    9'h042, 9'h0A5, 9'h05A,         // byte string of two bytes
    9'h060,                         // empty text string
    9'h09C, 9'h100,                 // reserved info, then drop to last byte
    9'h1C0,                         // tag on the last byte
    9'h0F7, 9'h1FF,                 // unknown simple, then drop
    9'h0F4, 9'h0F5, 9'h0F6,         // false, true, null
    9'h1B8,                         // map head cut short
    9'h161,                         // string head completed on the last byte
    9'h063, 9'h041, 9'h142          // string payload cut short
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  item_type;
    logic [63:0] head_value;
    logic        wide_value;
    logic [7:0]  payload_byte;
    logic        string_end;
    logic [2:0]  error_code;
  } cbor_result_t;

  // Software copy of the parser and the results it still owes.
  class cbor_decode_tracker;
    phase_t       phase;
    logic [2:0]   major;
    logic [4:0]   info;
    logic [3:0]   arg_left;
    logic [63:0]  acc;
    logic [63:0]  pay_left;
    cbor_result_t due_results[$];
    int           errors;

    function new();
      phase    = PH_HEAD;
      major    = '0;
      info     = '0;
      arg_left = '0;
      acc      = '0;
      pay_left = '0;
      errors   = 0;
    endfunction

    function void push_result(logic [1:0] kind, logic [3:0] itype, logic [63:0] value,
                              logic [7:0] pbyte, logic send, logic [2:0] code);
      cbor_result_t r;
      r.kind         = kind;
      r.item_type    = itype;
      r.head_value   = value;
      r.wide_value   = (kind == KIND_HEAD) && (value > 64'hFFFF_FFFF);
      r.payload_byte = pbyte;
      r.string_end   = send;
      r.error_code   = code;
      due_results.push_back(r);
    endfunction

    // An error on the last byte restarts at a head; otherwise drop bytes.
    function void raise_fault(logic [2:0] code, logic last);
      phase = last ? PH_HEAD : PH_DROP;
      push_result(KIND_ERROR, TYPE_UINT, '0, '0, 1'b0, code);
    endfunction

    // The argument is complete: classify the item or open a string payload.
    function void finish_head(logic last);
      logic [3:0]  itype;
      logic [63:0] value;
      value = acc;
      if (major == MAJOR_SIMPLE) begin
        if (info == INFO_FLOAT64) begin
          itype = TYPE_FLOAT64;
        end else if (info == INFO_NULL) begin
          itype = TYPE_NULL;
          value = '0;
        end else begin
          itype = TYPE_BOOL;
          value = {63'd0, info[0]};
        end
      end else begin
        itype = {1'b0, major};
      end
      phase = PH_HEAD;
      if ((itype == TYPE_BYTES || itype == TYPE_TEXT) && value != 64'd0) begin
        if (last) begin
          raise_fault(ERR_SHORT_STR, 1'b1);
          return;
        end
        pay_left = value;
        phase    = PH_PAY;
      end
      push_result(KIND_HEAD, itype, value, '0, 1'b0, ERR_NONE);
    endfunction

    // Advance the parse state by one transferred byte.
    function void take_byte(logic [7:0] b, logic last);
      case (phase)
        PH_DROP: begin
          if (last) phase = PH_HEAD;
        end
        PH_ARG: begin
          acc      = {acc[55:0], b};
          arg_left = arg_left - 4'd1;
          if (arg_left == 4'd0) finish_head(last);
          else if (last) raise_fault(ERR_SHORT_HEAD, 1'b1);
        end
        PH_PAY: begin
          if (pay_left <= 64'd1) begin
            pay_left = '0;
            phase    = PH_HEAD;
            push_result(KIND_PAYLOAD, {1'b0, major}, '0, b, 1'b1, ERR_NONE);
          end else if (last) begin
            raise_fault(ERR_SHORT_STR, 1'b1);
          end else begin
            pay_left = pay_left - 64'd1;
            push_result(KIND_PAYLOAD, {1'b0, major}, '0, b, 1'b0, ERR_NONE);
          end
        end
        default: begin
          major    = b[7:5];
          info     = b[4:0];
          acc      = '0;
          arg_left = '0;
          if (major == MAJOR_SIMPLE) begin
            if (b != BYTE_FALSE && b != BYTE_TRUE && b != BYTE_NULL && b != BYTE_FLOAT64) begin
              raise_fault(ERR_TAG_SIMPLE, last);
              return;
            end
          end else if (info >= INFO_RSVD) begin
            raise_fault(ERR_RSVD_INFO, last);
            return;
          end else if (major == MAJOR_TAG) begin
            raise_fault(ERR_TAG_SIMPLE, last);
            return;
          end
          if (info < INFO_ARG1) begin
            acc = {59'd0, info};
            finish_head(last);
          end else begin
            arg_left = 4'd1 << (info - INFO_ARG1);
            if (last) raise_fault(ERR_SHORT_HEAD, 1'b1);
            else phase = PH_ARG;
          end
        end
      endcase
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        errors++;
      end
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void match_result(cbor_result_t got);
      cbor_result_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing pending: kind %0d", got.kind);
        errors++;
        return;
      end
      want = due_results.pop_front();
      check_field("result_kind", 64'(want.kind), 64'(got.kind));
      check_field("item_type", 64'(want.item_type), 64'(got.item_type));
      check_field("head_value", want.head_value, got.head_value);
      check_field("wide_value", 64'(want.wide_value), 64'(got.wide_value));
      check_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
      check_field("string_end", 64'(want.string_end), 64'(got.string_end));
      check_field("error_code", 64'(want.error_code), 64'(got.error_code));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        in_is_last;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_result_kind;
  logic [3:0]  out_item_type;
  logic [63:0] out_head_value;
  logic        out_wide_value;
  logic [7:0]  out_payload_byte;
  logic        out_string_end;
  logic [2:0]  out_error_code;

  cbor_decode_tracker tracker;
  cbor_result_t       seen_result;
  logic [7:0]         frame_q[$];
  bit                 calm;
  int                 stall_left;
  int                 idle_cycles;

  cbor_item_stream_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_item_type    (out_item_type),
    .out_head_value   (out_head_value),
    .out_wide_value   (out_wide_value),
    .out_payload_byte (out_payload_byte),
    .out_string_end   (out_string_end),
    .out_error_code   (out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long; none while calm.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one byte and hold it until the parser takes it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    in_is_last <= last;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    tracker.take_byte(b, last);
  endtask

  // Append a head with its argument in the chosen width to the buffer.
  task automatic push_head(input logic [2:0] major, input logic [63:0] arg, input int sel);
    int n;
    if (sel == 0) begin
      frame_q.push_back({major, arg[4:0]});
    end else begin
      n = 1 << (sel - 1);
      frame_q.push_back({major, 5'(23 + sel)});
      for (int i = n - 1; i >= 0; i--) frame_q.push_back(arg[8*i +: 8]);
    end
  endtask

  // Result side stall pattern.
  initial begin
    out_stall <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!calm && $urandom_range(0, 2) == 0) stall_left = idle_span();
      end
    end
  end

  // A result transfer happens at the next rising edge; check it now.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_result.kind         = out_result_kind;
      seen_result.item_type    = out_item_type;
      seen_result.head_value   = out_head_value;
      seen_result.wide_value   = out_wide_value;
      seen_result.payload_byte = out_payload_byte;
      seen_result.string_end   = out_string_end;
      seen_result.error_code   = out_error_code;
      tracker.match_result(seen_result);
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  // Main stimulus.
  initial begin
    int          sent;
    int          cut;
    int          len;
    int          sel;
    logic [2:0]  maj;
    logic [63:0] arg;

    tracker = new();
    calm = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_byte    <= '0;
    in_is_last <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed buffers covering each result kind and each error code.
    for (int i = 0; i < OPENING_LEN; i++) send_byte(OPENING[i][7:0], OPENING[i][8]);

    // Random buffers: mostly well-formed items, some noise, corruption and cuts.
    sent = 0;
    while (sent < BYTE_TARGET) begin
      calm = ($urandom_range(0, 5) == 0);
      frame_q.delete();
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            case ($urandom_range(0, 3))
              0: maj = 3'd0;
              1: maj = 3'd1;
              2: maj = 3'd4;
              default: maj = 3'd5;
            endcase
            sel = $urandom_range(0, 4);
            case (sel)
              0: arg = 64'($urandom_range(0, 23));
              1: arg = 64'($urandom_range(0, 255));
              2: arg = 64'($urandom_range(0, 65535));
              3: arg = 64'($urandom);
              default: arg = {$urandom, $urandom};
            endcase
            push_head(maj, arg, sel);
          end
          4, 5, 6: begin
            maj = ($urandom_range(0, 1) == 0) ? MAJOR_BYTES : MAJOR_TEXT;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
            sel = (len < 24) ? $urandom_range(0, 4) : $urandom_range(1, 4);
            push_head(maj, 64'(len), sel);
            repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
          end
          7: begin
            case ($urandom_range(0, 2))
              0: frame_q.push_back(BYTE_FALSE);
              1: frame_q.push_back(BYTE_TRUE);
              default: frame_q.push_back(BYTE_NULL);
            endcase
          end
          8: begin
            frame_q.push_back(BYTE_FLOAT64);
            repeat (8) frame_q.push_back(8'($urandom_range(0, 255)));
          end
          default: frame_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      if ($urandom_range(0, 7) == 0)
        frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, frame_q.size());
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
      sent += frame_q.size();
    end
    in_valid <= 1'b0;
    calm = 1'b1;

    // Let every predicted result arrive, then watch for strays.
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
